@@ src/pcfla_pkg.sv @@
// ----------------------------------------------------------------------------
// pcfla_pkg
// shared types and constants of the power-of-two class free list allocator
// ----------------------------------------------------------------------------
package pcfla_pkg;

   // heap geometry
   localparam int HEAP_MAX_BYTES = 65536;
   localparam int GRAIN_BYTES    = 8;
   localparam int NUM_CLASSES    = 14;
   localparam int LINK_DEPTH     = HEAP_MAX_BYTES / GRAIN_BYTES;

   // field widths
   localparam int SIZE_W   = 17;
   localparam int ADDR_W   = 16;
   localparam int GRAIN_W  = $clog2(GRAIN_BYTES);
   localparam int IDX_W    = $clog2(LINK_DEPTH);
   localparam int LINK_W   = IDX_W + 1;
   localparam int CLS_W    = $clog2(NUM_CLASSES);
   localparam int MASK_W   = SIZE_W + NUM_CLASSES - 1;
   localparam int STATUS_W = 3;

   // bump limit ceiling
   localparam logic [SIZE_W-1:0] HEAP_LIMIT = SIZE_W'(HEAP_MAX_BYTES);

   // configuration port
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BYTES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BYTES  = 1'b1;
   localparam logic [SIZE_W-1:0] HEAP_BYTES_RST = SIZE_W'(65536);
   localparam logic [SIZE_W-1:0] MIN_BYTES_RST  = SIZE_W'(8);

   // stream packing
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   // queue between classifier and executor
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // request command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_SMALL    = 3'd1,
      ST_NOT_POW2 = 3'd2,
      ST_OOM      = 3'd3,
      ST_BAD_FREE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_ERROR = 2'd2
   } op_type;

   // classified request
   typedef struct packed {
      op_type             kind;
      logic [CLS_W-1:0]   cls;
      logic [SIZE_W-1:0]  size;
      logic [IDX_W-1:0]   idx;
      status_type         status;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_stat_type;

   typedef struct packed {
      logic take;
      logic pop_busy;
   } bk_stat_type;

endpackage

@@ src/pow2_class_free_list_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// pow2_class_free_list_allocator_unit
// heap allocator with one lifo free list per power-of-two size class
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tdata: size, free offset; tuser: command
//  rsp      out  rsp_tvalid/rsp_tready  tdata: status, block offset, granted size
//  csr      in   csr_we                 csr_index, csr_wdata
//
//  a request enters the two-entry queue in the cycle it is accepted and its
//  result sits in the output register from the cycle after the executor takes it
//  allocation from a non-empty list holds the executor in BK_POP for the link
//  store read; every other request leaves it in BK_IDLE
//  reset is synchronous: all lists empty, bump pointer zero, registers at
//  defaults; the link store needs no clearing pass
//  a stalled result stops the executor, the queue then fills and drops req_tready
// ----------------------------------------------------------------------------
module pow2_class_free_list_allocator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pcfla_pkg::REQ_TDATA_W-1:0]    req_tdata,  // req_size, free_addr, zero pad
   input  logic                                 req_tuser,  // cmd
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [pcfla_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // status, block_addr, granted_size, pad
   // register writes
   input  logic                                 csr_we,
   input  logic [pcfla_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pcfla_pkg::SIZE_W-1:0]         csr_wdata
);
   import pcfla_pkg::*;

   localparam int RSP_USED_W = STATUS_W + ADDR_W + SIZE_W;

   // configuration registers
   logic [SIZE_W-1:0] heap_bytes_ff, heap_bytes_in;
   logic [SIZE_W-1:0] min_bytes_ff, min_bytes_in;

   // request fields
   logic [SIZE_W-1:0] req_size;
   logic [ADDR_W-1:0] free_addr;

   // front to queue to back
   cmd_type     front_cmd;
   cmd_type     q_cmd;
   q_stat_type  q_stat;
   bk_stat_type bk_stat;
   logic        push;

   // back result
   status_type        rsp_status;
   logic [ADDR_W-1:0] rsp_block_addr;
   logic [SIZE_W-1:0] rsp_granted_size;

   always_comb begin
      heap_bytes_in = heap_bytes_ff;
      min_bytes_in  = min_bytes_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HEAP_BYTES: heap_bytes_in = csr_wdata;
            CSR_MIN_BYTES:  min_bytes_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_bytes_ff <= HEAP_BYTES_RST;
         min_bytes_ff  <= MIN_BYTES_RST;
      end else begin
         heap_bytes_ff <= heap_bytes_in;
         min_bytes_ff  <= min_bytes_in;
      end
   end

   // unpack the request
   assign req_size  = req_tdata[SIZE_W-1:0];
   assign free_addr = req_tdata[SIZE_W+ADDR_W-1:SIZE_W];

   assign req_tready = !q_stat.full;
   assign push       = req_tvalid && req_tready;

   // classification of the incoming request
   pcfla_front u_front (
      .req_cmd   (req_tuser),
      .req_size  (req_size),
      .free_addr (free_addr),
      .min_bytes (min_bytes_ff),
      .cmd       (front_cmd)
   );

   // decoupling queue
   pcfla_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (front_cmd),
      .pop      (bk_stat.take),
      .head_cmd (q_cmd),
      .stat     (q_stat)
   );

   // list and bump execution
   pcfla_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd              (q_cmd),
      .cmd_valid        (q_stat.valid),
      .heap_bytes       (heap_bytes_ff),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_status       (rsp_status),
      .rsp_block_addr   (rsp_block_addr),
      .rsp_granted_size (rsp_granted_size),
      .stat             (bk_stat)
   );

   // pack the result, status in the lowest bits
   assign rsp_tdata = {{(RSP_TDATA_W - RSP_USED_W){1'b0}},
                       rsp_granted_size, rsp_block_addr, rsp_status};

`ifndef ASSERT_OFF
   // BK_POP is never held: a list pop returns the executor straight to BK_IDLE
   a_pop_one_cycle: assert property (@(posedge clock) disable iff (reset)
      bk_stat.pop_busy |=> !bk_stat.pop_busy)
      else $error("list pop held the executor longer than one cycle");

   // the executor only takes requests that the queue holds
   a_take_has_entry: assert property (@(posedge clock) disable iff (reset)
      bk_stat.take |-> q_stat.valid)
      else $error("executor took a request from an empty queue");

   // no new request is taken while a pop is completing
   a_no_take_in_pop: assert property (@(posedge clock) disable iff (reset)
      bk_stat.pop_busy |-> !bk_stat.take)
      else $error("request taken during list pop");

   // a result only appears after the executor took a request
   a_rsp_from_take: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(bk_stat.take))
      else $error("result appeared without a request being taken");
`endif

endmodule

@@ src/pcfla_front.sv @@
// ----------------------------------------------------------------------------
// pcfla_front
// size class search and request checks
// ----------------------------------------------------------------------------
module pcfla_front (
   input  logic                         req_cmd,
   input  logic [pcfla_pkg::SIZE_W-1:0] req_size,
   input  logic [pcfla_pkg::ADDR_W-1:0] free_addr,
   input  logic [pcfla_pkg::SIZE_W-1:0] min_bytes,
   output pcfla_pkg::cmd_type           cmd
);
   import pcfla_pkg::*;

   logic [NUM_CLASSES-1:0] hit;
   logic [NUM_CLASSES-1:0] exact;
   logic [MASK_W-1:0]      mask;
   logic                   found;
   logic [CLS_W-1:0]       cls;

   // one mask per class, all independent
   always_comb begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
         mask     = MASK_W'(min_bytes) << k;
         hit[k]   = |(req_size & mask[SIZE_W-1:0]);
         exact[k] = (mask == MASK_W'(req_size));
      end
   end

   // lowest qualifying class wins
   always_comb begin
      found = 1'b0;
      cls   = '0;
      for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
         if (hit[k]) begin
            found = 1'b1;
            cls   = CLS_W'(k);
         end
      end
   end

   always_comb begin
      cmd.cls    = cls;
      cmd.size   = req_size;
      cmd.idx    = free_addr[ADDR_W-1:GRAIN_W];
      cmd.kind   = OP_ERROR;
      cmd.status = ST_OK;
      if (req_cmd == CMD_FREE) begin
         if (found) begin
            cmd.kind = OP_FREE;
         end else begin
            cmd.status = ST_BAD_FREE;
         end
      end else begin
         priority if (req_size < min_bytes) begin
            cmd.status = ST_SMALL;
         end else if (!found || !exact[cls]) begin
            cmd.status = ST_NOT_POW2;
         end else begin
            cmd.kind = OP_ALLOC;
         end
      end
   end

endmodule

@@ src/pcfla_queue.sv @@
// ----------------------------------------------------------------------------
// pcfla_queue
// short fifo of classified requests
// ----------------------------------------------------------------------------
module pcfla_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  pcfla_pkg::cmd_type     push_cmd,
   input  logic                   pop,
   output pcfla_pkg::cmd_type     head_cmd,
   output pcfla_pkg::q_stat_type  stat
);
   import pcfla_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) r = '0;
      else r = p + 1'b1;
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign stat.valid = (count_ff != '0);
   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));

endmodule

@@ src/pcfla_back.sv @@
// ----------------------------------------------------------------------------
// pcfla_back
// list heads, link store, bump pointer and result register
// ----------------------------------------------------------------------------
module pcfla_back (
   input  logic                           clock,
   input  logic                           reset,
   input  pcfla_pkg::cmd_type             cmd,
   input  logic                           cmd_valid,
   input  logic [pcfla_pkg::SIZE_W-1:0]   heap_bytes,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output pcfla_pkg::status_type          rsp_status,
   output logic [pcfla_pkg::ADDR_W-1:0]   rsp_block_addr,
   output logic [pcfla_pkg::SIZE_W-1:0]   rsp_granted_size,
   output pcfla_pkg::bk_stat_type         stat
);
   import pcfla_pkg::*;

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_POP  = 2'b10
   } bk_state_type;

   bk_state_type      state_ff, state_in;
   logic [IDX_W-1:0]  head_idx_ff [NUM_CLASSES];
   logic [IDX_W-1:0]  head_idx_in [NUM_CLASSES];
   logic [NUM_CLASSES-1:0] head_vld_ff, head_vld_in;
   logic [SIZE_W-1:0] bump_ff, bump_in;
   logic [CLS_W-1:0]  pop_cls_ff, pop_cls_in;

   logic [LINK_W-1:0] link_mem [LINK_DEPTH];
   logic [LINK_W-1:0] link_rd_ff;
   logic              link_rd_en;
   logic              link_wr_en;
   logic [LINK_W-1:0] link_wr_data;

   logic              rsp_vld_ff, rsp_vld_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [SIZE_W-1:0] rsp_size_ff, rsp_size_in;

   logic              out_free;
   logic              take;
   logic [SIZE_W-1:0] limit;
   logic [SIZE_W:0]   bump_sum;
   logic [IDX_W-1:0]  cls_head;
   logic              cls_vld;

   assign out_free = !rsp_vld_ff || rsp_tready;
   assign take     = (state_ff == BK_IDLE) && cmd_valid && out_free;
   assign limit    = (heap_bytes < HEAP_LIMIT) ? heap_bytes : HEAP_LIMIT;
   assign bump_sum = {1'b0, bump_ff} + {1'b0, cmd.size};
   assign cls_head = head_idx_ff[cmd.cls];
   assign cls_vld  = head_vld_ff[cmd.cls];
   assign link_wr_data = {cls_vld, cls_head};

   always_comb begin
      state_in      = state_ff;
      head_idx_in   = head_idx_ff;
      head_vld_in   = head_vld_ff;
      bump_in       = bump_ff;
      pop_cls_in    = pop_cls_ff;
      link_rd_en    = 1'b0;
      link_wr_en    = 1'b0;
      rsp_vld_in    = rsp_vld_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_size_in   = rsp_size_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (take) begin
               rsp_vld_in    = 1'b1;
               rsp_status_in = ST_OK;
               rsp_addr_in   = '0;
               rsp_size_in   = '0;
               unique case (cmd.kind)
                  OP_FREE: begin
                     // push: old head becomes the block's link
                     link_wr_en             = 1'b1;
                     head_idx_in[cmd.cls]   = cmd.idx;
                     head_vld_in[cmd.cls]   = 1'b1;
                     rsp_size_in            = cmd.size;
                  end
                  OP_ALLOC: begin
                     if (cls_vld) begin
                        // pop: fetch the link, the head moves in BK_POP
                        link_rd_en  = 1'b1;
                        pop_cls_in  = cmd.cls;
                        state_in    = BK_POP;
                        rsp_addr_in = {cls_head, GRAIN_W'(0)};
                        rsp_size_in = cmd.size;
                     end else if (bump_sum > {1'b0, limit}) begin
                        rsp_status_in = ST_OOM;
                     end else begin
                        rsp_addr_in = bump_ff[ADDR_W-1:0];
                        bump_in     = bump_sum[SIZE_W-1:0];
                        rsp_size_in = cmd.size;
                     end
                  end
                  default: begin
                     rsp_status_in = cmd.status;
                  end
               endcase
            end
         end
         BK_POP: begin
            head_idx_in[pop_cls_ff] = link_rd_ff[IDX_W-1:0];
            head_vld_in[pop_cls_ff] = link_rd_ff[IDX_W];
            state_in                = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         head_vld_ff <= '0;
         bump_ff     <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_vld_ff <= head_vld_in;
         bump_ff     <= bump_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      head_idx_ff   <= head_idx_in;
      pop_cls_ff    <= pop_cls_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_size_ff   <= rsp_size_in;
   end

   // link store, one write and one registered read
   always_ff @(posedge clock) begin
      if (link_wr_en) link_mem[cmd.idx] <= link_wr_data;
      if (link_rd_en) link_rd_ff <= link_mem[cls_head];
   end

   assign rsp_tvalid       = rsp_vld_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_block_addr   = rsp_addr_ff;
   assign rsp_granted_size = rsp_size_ff;
   assign stat.take        = take;
   assign stat.pop_busy    = (state_ff == BK_POP);

endmodule
